// File: hw/rtl/ipow_pkg.sv
// shared types and constants for the integer power block
// used by ipow_ctrl, ipow_datapath and integer_power_by_squaring
package ipow_pkg;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_FINISH
    } t_state;

    // partial product steps of one 64-bit wrapped multiply on a 32x32 unit
    typedef enum logic [1:0] {
        STEP_LL,
        STEP_LH,
        STEP_HL
    } t_step;

    // commands from controller to datapath
    typedef struct packed {
        logic  load;      // take a new item
        logic  mul_en;    // run one multiply step
        t_step step;      // which partial product
        logic  dst_sq;    // 1: square register is written, 0: accumulator
        logic  shift;     // move to the next exponent bit
        logic  out_load;  // capture the result into the output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic exp_zero;   // no exponent bits left
        logic exp_bit0;   // current exponent bit
        logic exp_last;   // current bit is the top remaining one
        logic narrow;     // 32-bit word selected, one step per multiply
    } t_dp_status;

    localparam logic [63:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;

endpackage

// File: hw/rtl/ipow_datapath.sv
// datapath: accumulator, square and exponent registers, shared 32x32 multiplier
// and output register; depends on ipow_pkg
module ipow_datapath import ipow_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_mode,
    input  logic signed [63:0] i_base_value,
    input  logic signed [31:0] i_exponent,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic signed [63:0] o_power_result
);

    localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_BITS);

    logic [63:0] r_acc, n_acc;
    logic [63:0] r_sq, n_sq;
    logic [30:0] r_exp, n_exp;
    logic [63:0] r_prod, n_prod;
    logic [31:0] r_hi, n_hi;
    logic [63:0] r_out, n_out;

    logic [63:0] mul_x;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_res;
    logic        mul_wr;
    logic        narrow;
    logic        exp_pos;
    logic [63:0] ext_mask;
    logic        ext_sign;

    assign narrow  = !i_mode || (WORD_BITS <= 32);
    assign exp_pos = !i_exponent[31] && (i_exponent != 32'sd0);

    // operand selection for the shared multiplier
    assign mul_x = i_cmd.dst_sq ? r_sq : r_acc;
    always_comb begin
        case (i_cmd.step)
            STEP_LL: begin
                mul_a = mul_x[31:0];
                mul_b = r_sq[31:0];
            end
            STEP_LH: begin
                mul_a = mul_x[31:0];
                mul_b = r_sq[63:32];
            end
            STEP_HL: begin
                mul_a = mul_x[63:32];
                mul_b = r_sq[31:0];
            end
            default: begin
                mul_a = mul_x[31:0];
                mul_b = r_sq[31:0];
            end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // final value and write strobe of a multiply
    always_comb begin
        mul_wr  = 1'b0;
        mul_res = mul_p;
        if (i_cmd.mul_en) begin
            case (i_cmd.step)
                STEP_LL: mul_wr = narrow;
                STEP_HL: begin
                    mul_wr  = 1'b1;
                    mul_res = {r_hi + mul_p[31:0], r_prod[31:0]};
                end
                default: mul_wr = 1'b0;
            endcase
        end
    end

    // sign extension from the selected word width
    always_comb begin
        ext_mask = i_mode ? WMASK : MASK_32;
        ext_sign = i_mode ? r_acc[WORD_BITS-1] : r_acc[31];
    end

    // register updates
    always_comb begin
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_exp  = r_exp;
        n_prod = r_prod;
        n_hi   = r_hi;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_acc = 64'd1;
            n_sq  = i_base_value;
            n_exp = exp_pos ? i_exponent[30:0] : 31'd0;
        end
        if (i_cmd.mul_en && (i_cmd.step == STEP_LL)) begin
            n_prod = mul_p;
        end
        if (i_cmd.mul_en && (i_cmd.step == STEP_LH)) begin
            n_hi = r_prod[63:32] + mul_p[31:0];
        end
        if (mul_wr) begin
            if (i_cmd.dst_sq) begin
                n_sq = mul_res;
            end else begin
                n_acc = mul_res;
            end
        end
        if (i_cmd.shift) begin
            n_exp = {1'b0, r_exp[30:1]};
        end
        if (i_cmd.out_load) begin
            n_out = ext_sign ? (r_acc | ~ext_mask) : (r_acc & ext_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_exp  <= n_exp;
        r_prod <= n_prod;
        r_hi   <= n_hi;
        r_out  <= n_out;
    end

    // status back to the controller
    always_comb begin
        o_status.exp_zero = (r_exp == 31'd0);
        o_status.exp_bit0 = r_exp[0];
        o_status.exp_last = (r_exp[30:1] == 30'd0);
        o_status.narrow   = narrow;
    end

    assign o_power_result = r_out;

endmodule

// File: hw/rtl/ipow_ctrl.sv
// controller: sequences square-and-multiply over the exponent bits and
// owns the handshakes; depends on ipow_pkg
module ipow_ctrl import ipow_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_dst_sq, n_dst_sq;
    logic   r_out_valid, n_out_valid;
    logic   mul_done;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_LL;
            r_dst_sq    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_dst_sq    <= n_dst_sq;
            r_out_valid <= n_out_valid;
        end
    end

    assign mul_done = (r_step == STEP_HL) || (i_status.narrow && (r_step == STEP_LL));

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_dst_sq     = r_dst_sq;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        o_cmd.dst_sq = r_dst_sq;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.exp_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_dst_sq = !i_status.exp_bit0;
                    n_step   = STEP_LL;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (mul_done) begin
                    n_step = STEP_LL;
                    if (r_dst_sq) begin
                        // square finished, next exponent bit
                        o_cmd.shift = 1'b1;
                        n_state     = S_CHECK;
                    end else if (i_status.exp_last) begin
                        n_state = S_FINISH;
                    end else begin
                        n_dst_sq = 1'b1;
                    end
                end else begin
                    n_step = (r_step == STEP_LL) ? STEP_LH : STEP_HL;
                end
            end
            S_FINISH: begin
                // wait for the output register to be free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/integer_power_by_squaring.sv
// top level of the integer power block: width register, controller and datapath
// depends on ipow_pkg, ipow_ctrl and ipow_datapath
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_base_value[63:0], i_exponent[31:0]
//  out      output     o_out_valid / i_out_stall o_power_result[63:0]
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (word width mode)
//
// one 32x32 multiplier does all products: a wrapped 64-bit multiply runs the partial
// products LL, LH and HL, a 32-bit one only LL. per exponent bit up to the top set bit:
// a check, a multiply if the bit is set, a square unless it is the top bit.
// an item passes through accept, the per-bit steps and finish before its result is offered.
// synchronous active-low reset sets the width mode to 1; the next item is taken
// while a result waits on a stalled output, and the block holds in finish until it leaves.
module integer_power_by_squaring import ipow_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [63:0] i_base_value,
    input  logic signed [31:0] i_exponent,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_power_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic       r_mode;
    t_dp_cmd    cmd;
    t_dp_status status;

    // word width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    ipow_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ipow_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_mode         (r_mode),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_power_result (o_power_result)
    );

endmodule

// File: dv/tb_top.sv
// testbench for integer_power_by_squaring: directed and random items with both word widths
// depends on ipow_pkg and the integer_power_by_squaring rtl
// a scoreboard class predicts each power and checks results in order
module tb_top import ipow_pkg::*;;

    // values of the width register
    localparam logic MODE_32 = 1'b0;
    localparam logic MODE_64 = 1'b1;

    // cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 370;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [63:0] i_base_value;
    logic signed [31:0] i_exponent;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [63:0] o_power_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_data;

    // no random idling on either side while set
    logic calm;
    int   width_writes;

    // expected powers in order, with a private copy of the width mode
    class power_scoreboard;
        logic [63:0] pending_powers[$];
        logic        wide_mode;
        int          errors;
        int          wide_items;
        int          narrow_items;

        function new();
            wide_mode = MODE_64;
            errors = 0;
            wide_items = 0;
            narrow_items = 0;
        endfunction

        // square and multiply, wrapped to the selected word and sign-extended
        function automatic logic [63:0] compute_power(logic [63:0] b, logic [31:0] e);
            logic [63:0] acc;
            logic [63:0] sq;
            logic [31:0] k;
            acc = 64'd1;
            if (e != 32'd0 && !e[31]) begin
                sq = (wide_mode == MODE_64) ? b : (b & MASK_32);
                k = e;
                while (k != 32'd0) begin
                    if (k[0]) acc = acc * sq;
                    sq = sq * sq;
                    k = k >> 1;
                end
            end
            if (wide_mode == MODE_32) acc = {{32{acc[31]}}, acc[31:0]};
            return acc;
        endfunction

        function void set_mode(logic m);
            wide_mode = m;
        endfunction

        function void record_operands(logic [63:0] b, logic [31:0] e);
            pending_powers.push_back(compute_power(b, e));
            if (wide_mode == MODE_64) wide_items++;
            else narrow_items++;
        endfunction

        function void check_power(logic [63:0] actual);
            logic [63:0] expected;
            if (pending_powers.size() == 0) begin
                $error("power_result with no pending item: actual %0d", $signed(actual));
                errors++;
            end else begin
                expected = pending_powers.pop_front();
                if (actual !== expected) begin
                    $error("power_result mismatch: expected %0d, actual %0d",
                           $signed(expected), $signed(actual));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_powers.size();
        endfunction
    endclass

    power_scoreboard sb;

    integer_power_by_squaring dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result side: check accepted items, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_power(o_power_result);
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
    end

    // hang detection: cycles with no handshake on any channel
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one item on the input channel, with random idle cycles ahead of it
    task automatic send_item(logic [63:0] b, logic [31:0] e);
        while (!calm && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            i_base_value <= {$urandom, $urandom};
            i_exponent <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base_value <= b;
        i_exponent <= e;
        do @(posedge i_clk); while (o_in_stall);
        sb.record_operands(b, e);
    endtask

    // hold off the sender until every expected result has come
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // width register write, only once the block is drained
    task automatic write_width(logic m);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mode(m);
        width_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // random items: small exponents most often, some full range and negative ones
    task automatic run_random(int count, bit quiet_stretch, bit mid_pause);
        logic [63:0] b;
        logic [31:0] e;
        logic [31:0] r;
        for (int i = 0; i < count; i++) begin
            calm <= quiet_stretch && (i < count / 3);
            if (mid_pause && i == count / 2) wait_drained();
            r = $urandom;
            case ($urandom_range(3))
                0: b = {$urandom, $urandom};
                1: b = $signed(64'($urandom_range(32))) - 64'sd16;
                2: b = {{32{r[31]}}, r};
                default: begin
                    case ($urandom_range(6))
                        0: b = 64'd0;
                        1: b = 64'd1;
                        2: b = '1;
                        3: b = 64'd2;
                        4: b = 64'd10;
                        5: b = 64'h8000_0000_0000_0000;
                        default: b = 64'h7FFF_FFFF_FFFF_FFFF;
                    endcase
                end
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: e = $urandom_range(70);
                4, 5: e = $urandom;
                6: e = {1'b1, r[30:0]};
                7, 8: e = $urandom_range(32'h7FFF_FFFF, 1);
                default: e = 32'd0;
            endcase
            send_item(b, e);
        end
        calm <= 1'b0;
    endtask

    // stimulus
    initial begin
        sb = new();
        calm <= 1'b0;
        width_writes = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_base_value <= '0;
        i_exponent <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, 64-bit word from reset
        send_item(64'd12345, 32'd0);
        send_item(64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
        send_item(64'd7, 32'h8000_0000);
        send_item(64'd3, 32'h7FFF_FFFF);
        send_item(64'd0, 32'd5);
        send_item(64'd0, 32'd0);
        send_item(64'h8000_0000_0000_0000, 32'd1);
        send_item(64'h8000_0000_0000_0000, 32'd2);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 32'd2);
        send_item('1, 32'd7);
        send_item('1, 32'd8);
        send_item(64'd2, 32'd63);
        send_item(64'd2, 32'd64);
        send_item(64'd10, 32'd19);
        send_item(64'd10, 32'd20);

        // directed, 32-bit word: upper base bits ignored, sign extension
        write_width(MODE_32);
        send_item(64'hFFFF_FFFF_0000_0003, 32'd3);
        send_item(64'h0000_0000_8000_0000, 32'd1);
        send_item(64'd2, 32'd31);
        send_item(64'd2, 32'd32);
        send_item(64'd10, 32'd9);
        send_item(64'd10, 32'd10);
        send_item(64'h7FFF_FFFF_7FFF_FFFF, 32'd2);
        send_item(64'd5, 32'h7FFF_FFFF);

        run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);
        write_width(MODE_64);
        run_random(RANDOM_PER_PHASE, 1'b1, 1'b0);
        write_width(MODE_32);
        run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);
        write_width(MODE_64);
        run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);

        // drain, then watch for stray results
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("power_result: %0d expected items never came out", sb.pending());
            sb.errors++;
        end
        $display("ran %0d items on the 64-bit word and %0d on the 32-bit word,",
                 sb.wide_items, sb.narrow_items);
        $display("with %0d width register writes and random stalls on both sides",
                 width_writes);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: integer_power_by_squaring.f
hw/rtl/ipow_pkg.sv
hw/rtl/ipow_datapath.sv
hw/rtl/ipow_ctrl.sv
hw/rtl/integer_power_by_squaring.sv
dv/tb_top.sv
